// ===== src/hci_pkg.sv =====
package hci_pkg;

   localparam int unsigned DATA_WORDS_DEFAULT = 1024;
   localparam int unsigned WORD_W = 16;
   localparam int unsigned PC_W = 15;
   localparam int unsigned INST_W = 16;
   localparam int unsigned MADDR_W = 10;
   localparam int unsigned FAULT_W = 2;
   localparam int unsigned RSP_W = 96;

   localparam logic [15:0] PLEN_RESET = 16'h8000;

   localparam logic [1:0] FAULT_OK    = 2'd0;
   localparam logic [1:0] FAULT_COMP  = 2'd1;
   localparam logic [1:0] FAULT_RANGE = 2'd2;

   typedef struct packed {
      logic [15:0] a;
      logic [15:0] d;
      logic [14:0] pc;
   } cpu_state_type;

   typedef struct packed {
      logic [14:0] next_pc;
      logic        jump_taken;
      logic [15:0] alu_value;
      logic [15:0] a_value;
      logic [15:0] d_value;
      logic        mem_write;
      logic [1:0]  fault;
   } exec_result_type;

   // {a, zx nx zy ny f no}: true for the 28 published comp codes
   function automatic logic comp_valid(input logic [6:0] code);
      logic ok;
      case (code) inside
         7'h2A, 7'h3F, 7'h3A, 7'h0C, 7'h30, 7'h0D, 7'h31, 7'h0F, 7'h33,
         7'h1F, 7'h37, 7'h0E, 7'h32, 7'h02, 7'h13, 7'h07, 7'h00, 7'h15,
         7'h70, 7'h71, 7'h73, 7'h77, 7'h72, 7'h42, 7'h53, 7'h47, 7'h40,
         7'h55: begin
            ok = 1'b1;
         end
         default: begin
            ok = 1'b0;
         end
      endcase
      return ok;
   endfunction

endpackage

// ===== src/hci_ram.sv =====
module hci_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/hci_alu.sv =====
module hci_alu (
   input  logic [15:0]              inst,
   input  hci_pkg::cpu_state_type   state,
   input  logic [15:0]              m_value,
   input  logic [15:0]              plen,
   output hci_pkg::exec_result_type res
);

   logic        use_m;
   logic [5:0]  comp;
   logic [15:0] x0, x1, y0, y1, f_out, alu_out;
   logic        neg, zero, jump;
   logic [14:0] pc_inc, next;
   logic [1:0]  fault;

   assign use_m = inst[12];
   assign comp  = inst[11:6];

   always_comb begin
      x0 = comp[5] ? 16'h0000 : state.d;
      x1 = comp[4] ? ~x0 : x0;
      y0 = comp[3] ? 16'h0000 : (use_m ? m_value : state.a);
      y1 = comp[2] ? ~y0 : y0;
      f_out = comp[1] ? (x1 + y1) : (x1 & y1);
      alu_out = comp[0] ? ~f_out : f_out;
   end

   assign neg  = alu_out[15];
   assign zero = (alu_out == 16'h0000);
   assign pc_inc = state.pc + 15'd1;

   always_comb begin
      res = '0;
      res.a_value = state.a;
      res.d_value = state.d;
      next = pc_inc;
      fault = hci_pkg::FAULT_OK;
      jump = 1'b0;
      if (!inst[15]) begin
         res.a_value = {1'b0, inst[14:0]};
      end else if (!hci_pkg::comp_valid({use_m, comp})) begin
         fault = hci_pkg::FAULT_COMP;
         next = state.pc;
      end else begin
         jump = (inst[2] & neg) | (inst[1] & zero) | (inst[0] & ~neg & ~zero);
         res.alu_value = alu_out;
         if (inst[5]) begin
            res.a_value = alu_out;
         end
         if (inst[4]) begin
            res.d_value = alu_out;
         end
         res.mem_write = inst[3];
         // target is A before this instruction's write
         if (jump) begin
            next = state.a[14:0];
         end
      end
      if (fault == hci_pkg::FAULT_OK && {1'b0, next} >= plen) begin
         fault = hci_pkg::FAULT_RANGE;
      end
      if (fault != hci_pkg::FAULT_OK) begin
         res.a_value = state.a;
         res.d_value = state.d;
         res.mem_write = 1'b0;
      end
      res.next_pc = next;
      res.jump_taken = jump;
      res.fault = fault;
   end

endmodule

// ===== src/hack_cpu_instruction_execute.sv =====
// Hack CPU execute block: one instruction word in, one result word out.
// req_* carries the 16-bit instruction; rsp_* returns next pc, jump flag,
// ALU value, A and D after the instruction, the data memory write (flag,
// address, data) and a fault code. csr_* writes program_length; the user
// must change it only while idle; the block itself does not enforce it.
// Path: a word accepted into the input register moves on to the result
// register, which drives rsp_tvalid. Throughput: one word per cycle while
// rsp_tready does not stall; the ALU, the jump test and the data memory
// read/write all close between the two registers; M is read from a
// registered-read RAM at next-cycle A, plus a one-entry write bypass.
// Reset: A, D and pc go to zero, program_length to 32768, and a clearing
// pass writes zero to every data memory word while req_tready stays low.
// A stalled rsp_tready holds the result word; one more instruction word
// is taken into the input register, then req_tready drops.
// DATA_WORDS must be a power of two; M is memory[A mod DATA_WORDS].
module hack_cpu_instruction_execute #(
   parameter int unsigned DATA_WORDS = hci_pkg::DATA_WORDS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // instruction [15:0]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,
   // next_pc [14:0], jump_taken [15], alu_value [31:16], a_value [47:32],
   // d_value [63:48], mem_write [64], mem_address [74:65],
   // mem_data [90:75], fault [92:91], zero [95:93]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);

   localparam int unsigned AW = $clog2(DATA_WORDS);

   logic        inst_vld_ff, inst_vld_in;
   logic [15:0] inst_ff, inst_in;
   logic        rsp_vld_ff, rsp_vld_in;
   logic [95:0] rsp_data_ff, rsp_data_in;
   logic [15:0] a_reg_ff, a_reg_in;
   logic [15:0] d_reg_ff, d_reg_in;
   logic [14:0] pc_reg_ff, pc_reg_in;
   logic [15:0] plen_ff, plen_in;
   logic          clear_busy_ff, clear_busy_in;
   logic [AW-1:0] clear_cnt_ff, clear_cnt_in;
   logic          fwd_vld_ff, fwd_vld_in;
   logic [15:0]   fwd_data_ff, fwd_data_in;

   logic          req_fire, exec_fire, commit;
   logic [AW-1:0] a_addr, rd_addr, wr_addr;
   logic          wr_en;
   logic [15:0]   wr_data, ram_rd_data, m_value, a_addr_ext;
   logic [9:0]    out_addr;
   logic [15:0]   out_data;
   hci_pkg::cpu_state_type   state;
   hci_pkg::exec_result_type res;

   assign state = '{a: a_reg_ff, d: d_reg_ff, pc: pc_reg_ff};
   assign m_value = fwd_vld_ff ? fwd_data_ff : ram_rd_data;

   hci_alu u_alu (
      .inst    (inst_ff),
      .state   (state),
      .m_value (m_value),
      .plen    (plen_ff),
      .res     (res)
   );

   assign exec_fire = inst_vld_ff & (~rsp_vld_ff | rsp_tready);
   assign req_tready = ~clear_busy_ff & (~inst_vld_ff | exec_fire);
   assign req_fire = req_tvalid & req_tready;
   assign commit = exec_fire & (res.fault == hci_pkg::FAULT_OK);

   assign inst_vld_in = req_fire | (inst_vld_ff & ~exec_fire);
   assign inst_in = req_fire ? req_tdata : inst_ff;
   assign rsp_vld_in = exec_fire | (rsp_vld_ff & ~rsp_tready);

   assign a_reg_in = commit ? res.a_value : a_reg_ff;
   assign d_reg_in = commit ? res.d_value : d_reg_ff;
   assign pc_reg_in = commit ? res.next_pc : pc_reg_ff;
   assign plen_in = csr_valid ? csr_data : plen_ff;
   assign csr_ready = 1'b1;

   assign a_addr = a_reg_ff[AW-1:0];
   assign a_addr_ext = {{(16 - AW){1'b0}}, a_addr};
   assign out_addr = res.mem_write ? a_addr_ext[9:0] : 10'd0;
   assign out_data = res.mem_write ? res.alu_value : 16'h0000;

   assign rsp_data_in = {3'b000, res.fault, out_data, out_addr, res.mem_write,
                         res.d_value, res.a_value, res.alu_value,
                         res.jump_taken, res.next_pc};

   // clearing pass after reset, then memory writes from instructions
   assign clear_busy_in = clear_busy_ff & (clear_cnt_ff != AW'(DATA_WORDS - 1));
   assign clear_cnt_in = clear_busy_ff ? clear_cnt_ff + AW'(1) : clear_cnt_ff;
   assign wr_en = clear_busy_ff | (exec_fire & res.mem_write);
   assign wr_addr = clear_busy_ff ? clear_cnt_ff : a_addr;
   assign wr_data = clear_busy_ff ? 16'h0000 : res.alu_value;

   // read M for the A of the next cycle; bypass a same-cycle write
   assign rd_addr = a_reg_in[AW-1:0];
   assign fwd_vld_in = wr_en & (wr_addr == rd_addr);
   assign fwd_data_in = wr_data;

   hci_ram #(
      .WIDTH (hci_pkg::WORD_W),
      .DEPTH (DATA_WORDS)
   ) u_data_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         inst_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
         a_reg_ff <= '0;
         d_reg_ff <= '0;
         pc_reg_ff <= '0;
         plen_ff <= hci_pkg::PLEN_RESET;
         clear_busy_ff <= 1'b1;
         clear_cnt_ff <= '0;
         fwd_vld_ff <= 1'b0;
      end else begin
         inst_vld_ff <= inst_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         a_reg_ff <= a_reg_in;
         d_reg_ff <= d_reg_in;
         pc_reg_ff <= pc_reg_in;
         plen_ff <= plen_in;
         clear_busy_ff <= clear_busy_in;
         clear_cnt_ff <= clear_cnt_in;
         fwd_vld_ff <= fwd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      inst_ff <= inst_in;
      fwd_data_ff <= fwd_data_in;
      if (exec_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata = rsp_data_ff;

endmodule

// ===== src/hci_checker.sv =====
module hci_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [95:0] rsp_tdata
);

   // a held result word does not change
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result word changed while stalled");

   a_fault_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[92:91] <= hci_pkg::FAULT_RANGE)
      else $error("undefined fault code");

   // a faulting word never writes memory
   a_fault_no_write: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[92:91] != hci_pkg::FAULT_OK |-> !rsp_tdata[64])
      else $error("memory write reported with fault");

   a_idle_mem_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[64] |-> rsp_tdata[90:65] == 26'd0)
      else $error("memory address or data without write");

   // bad comp code: nothing computed, no jump
   a_comp_fault: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[92:91] == hci_pkg::FAULT_COMP |->
         !rsp_tdata[15] && rsp_tdata[31:16] == 16'h0000)
      else $error("comp fault with jump or ALU value");

endmodule

bind hack_cpu_instruction_execute hci_checker u_hci_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== tb/tb_hack_cpu_instruction_execute.sv =====
module tb_hack_cpu_instruction_execute;

   localparam int unsigned HOLD_CYCLES = 300;
   localparam int unsigned COMP_COUNT = 28;

   // {a, zx nx zy ny f no}
   localparam logic [6:0] COMP_ZERO      = 7'h2A;
   localparam logic [6:0] COMP_ONE       = 7'h3F;
   localparam logic [6:0] COMP_MINUS_1   = 7'h3A;
   localparam logic [6:0] COMP_D         = 7'h0C;
   localparam logic [6:0] COMP_A         = 7'h30;
   localparam logic [6:0] COMP_M         = 7'h70;
   localparam logic [6:0] COMP_D_PLUS_1  = 7'h1F;
   localparam logic [6:0] COMP_BAD_A     = 7'h01;
   localparam logic [6:0] COMP_BAD_M     = 7'h6A;

   localparam logic [2:0] DEST_NONE = 3'b000;
   localparam logic [2:0] DEST_M    = 3'b001;
   localparam logic [2:0] DEST_D    = 3'b010;
   localparam logic [2:0] DEST_A    = 3'b100;

   localparam logic [2:0] JMP_NONE   = 3'b000;
   localparam logic [2:0] JMP_ALWAYS = 3'b111;

   localparam logic [1:0] FILL_SET   = 2'b11;
   localparam logic [1:0] FILL_CLEAR = 2'b00;

   typedef struct packed {
      logic [14:0] next_pc;
      logic        jump_taken;
      logic [15:0] alu_value;
      logic [15:0] a_value;
      logic [15:0] d_value;
      logic        mem_write;
      logic [9:0]  mem_address;
      logic [15:0] mem_data;
      logic [1:0]  fault;
   } step_outcome_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data = '0;

   logic [6:0] comp_list [COMP_COUNT] = '{
      7'h2A, 7'h3F, 7'h3A, 7'h0C, 7'h30, 7'h0D, 7'h31, 7'h0F, 7'h33,
      7'h1F, 7'h37, 7'h0E, 7'h32, 7'h02, 7'h13, 7'h07, 7'h00, 7'h15,
      7'h70, 7'h71, 7'h73, 7'h77, 7'h72, 7'h42, 7'h53, 7'h47, 7'h40,
      7'h55};

   // predicted machine state
   logic [15:0] cpu_a;
   logic [15:0] cpu_d;
   logic [14:0] cpu_pc;
   logic [15:0] prog_len;
   logic [15:0] data_mem [1024];

   step_outcome_type outcome_q [$];
   step_outcome_type want;
   int unsigned   error_count = 0;
   int unsigned   tx_idle_pct = 0;
   int unsigned   rx_idle_pct = 0;
   int unsigned   hold_token = 0;
   int unsigned   hold_seen = 0;
   int unsigned   hold_left = 0;

   hack_cpu_instruction_execute dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #2 clock = ~clock;

   function automatic logic [15:0] a_inst(input logic [14:0] value);
      return {1'b0, value};
   endfunction

   function automatic logic [15:0] c_inst(input logic [1:0] fill, input logic [6:0] comp,
                                          input logic [2:0] dest, input logic [2:0] jmp);
      return {1'b1, fill, comp, dest, jmp};
   endfunction

   function automatic logic [15:0] rand_instruction(input int unsigned a_span);
      int unsigned pick;
      logic [31:0] bits;
      pick = $urandom_range(0, 99);
      bits = $urandom;
      if (pick < 10) begin
         return bits[15:0];
      end
      if (pick < 40) begin
         if (bits[31]) begin
            return a_inst(bits[14:0]);
         end
         return a_inst(15'($urandom_range(0, a_span - 1)));
      end
      return c_inst(bits[1:0], comp_list[$urandom_range(0, COMP_COUNT - 1)],
                    bits[4:2], bits[7:5]);
   endfunction

   // executes one instruction on the predicted state
   task automatic execute_instruction(input logic [15:0] inst, output step_outcome_type r);
      logic [15:0] new_a, new_d, alu, x, y;
      logic [14:0] nxt;
      logic [9:0]  addr;
      logic [6:0]  comp;
      logic        jmp, wr, neg, zer, known;
      logic [1:0]  flt;
      new_a = cpu_a;
      new_d = cpu_d;
      alu = '0;
      nxt = cpu_pc + 15'd1;
      addr = cpu_a[9:0];
      jmp = 1'b0;
      wr = 1'b0;
      flt = hci_pkg::FAULT_OK;
      if (!inst[15]) begin
         new_a = {1'b0, inst[14:0]};
      end else begin
         comp = inst[12:6];
         known = 1'b0;
         for (int i = 0; i < COMP_COUNT; i++) begin
            if (comp_list[i] == comp) known = 1'b1;
         end
         if (!known) begin
            flt = hci_pkg::FAULT_COMP;
            nxt = cpu_pc;
         end else begin
            x = cpu_d;
            y = inst[12] ? data_mem[addr] : cpu_a;
            if (inst[11]) x = '0;
            if (inst[10]) x = ~x;
            if (inst[9]) y = '0;
            if (inst[8]) y = ~y;
            alu = inst[7] ? x + y : x & y;
            if (inst[6]) alu = ~alu;
            neg = alu[15];
            zer = (alu == '0);
            jmp = (inst[2] && neg) || (inst[1] && zer) || (inst[0] && !neg && !zer);
            if (inst[5]) new_a = alu;
            if (inst[4]) new_d = alu;
            wr = inst[3];
            // target is A before this instruction's write
            if (jmp) nxt = cpu_a[14:0];
         end
      end
      if (flt == hci_pkg::FAULT_OK && {1'b0, nxt} >= prog_len) flt = hci_pkg::FAULT_RANGE;
      if (flt == hci_pkg::FAULT_OK) begin
         if (wr) data_mem[addr] = alu;
         cpu_a = new_a;
         cpu_d = new_d;
         cpu_pc = nxt;
      end else begin
         wr = 1'b0;
      end
      r.next_pc = nxt;
      r.jump_taken = jmp;
      r.alu_value = alu;
      r.a_value = cpu_a;
      r.d_value = cpu_d;
      r.mem_write = wr;
      r.mem_address = wr ? addr : '0;
      r.mem_data = wr ? alu : '0;
      r.fault = flt;
   endtask

   task automatic send_word(input logic [15:0] inst);
      step_outcome_type r;
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= inst;
      do @(posedge clock); while (!req_tready);
      execute_instruction(inst, r);
      outcome_q.push_back(r);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (outcome_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_prog_length(input logic [15:0] value);
      wait_idle();
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      prog_len = value;
   endtask

   task automatic set_idle(input int unsigned tx_pct, input int unsigned rx_pct);
      tx_idle_pct = tx_pct;
      rx_idle_pct <= rx_pct;
   endtask

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want_v);
      $display("mismatch %s: got %h expected %h", what, got, want_v);
      error_count++;
   endtask

   // result side: random stalls plus an optional long hold-off
   always @(posedge clock) begin
      if (hold_token != hold_seen) begin
         hold_seen = hold_token;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) begin
         if (outcome_q.size() == 0) begin
            report_mismatch("unexpected word", rsp_tdata[15:0], '0);
         end else begin
            want = outcome_q.pop_front();
            if (rsp_tdata[14:0] !== want.next_pc)
               report_mismatch("next_pc", 16'(rsp_tdata[14:0]), 16'(want.next_pc));
            if (rsp_tdata[15] !== want.jump_taken)
               report_mismatch("jump_taken", 16'(rsp_tdata[15]), 16'(want.jump_taken));
            if (rsp_tdata[31:16] !== want.alu_value)
               report_mismatch("alu_value", rsp_tdata[31:16], want.alu_value);
            if (rsp_tdata[47:32] !== want.a_value)
               report_mismatch("a_value", rsp_tdata[47:32], want.a_value);
            if (rsp_tdata[63:48] !== want.d_value)
               report_mismatch("d_value", rsp_tdata[63:48], want.d_value);
            if (rsp_tdata[64] !== want.mem_write)
               report_mismatch("mem_write", 16'(rsp_tdata[64]), 16'(want.mem_write));
            if (rsp_tdata[74:65] !== want.mem_address)
               report_mismatch("mem_address", 16'(rsp_tdata[74:65]),
                               16'(want.mem_address));
            if (rsp_tdata[90:75] !== want.mem_data)
               report_mismatch("mem_data", rsp_tdata[90:75], want.mem_data);
            if (rsp_tdata[92:91] !== want.fault)
               report_mismatch("fault", 16'(rsp_tdata[92:91]), 16'(want.fault));
            if (rsp_tdata[95:93] !== 3'b000)
               report_mismatch("pad", 16'(rsp_tdata[95:93]), '0);
         end
      end
   end

   task automatic test_a_loads();
      send_word(a_inst(15'h0000));
      send_word(a_inst(15'h7FFF));
      send_word(a_inst(15'h2AAA));
      send_word(a_inst(15'h5555));
   endtask

   task automatic test_every_comp();
      send_word(a_inst(15'd5));
      send_word(c_inst(FILL_SET, COMP_A, DEST_D, JMP_NONE));
      send_word(a_inst(15'd9));
      send_word(c_inst(FILL_SET, COMP_D, DEST_M, JMP_NONE));
      send_word(c_inst(FILL_SET, COMP_MINUS_1, DEST_D, JMP_NONE));
      for (int i = 0; i < COMP_COUNT; i++) begin
         send_word(c_inst(FILL_SET, comp_list[i], 3'(i), 3'(i * 3)));
      end
   endtask

   task automatic test_bad_comp();
      send_word(c_inst(FILL_SET, COMP_BAD_A, DEST_A | DEST_D | DEST_M, JMP_ALWAYS));
      send_word(c_inst(FILL_SET, COMP_BAD_M, DEST_A | DEST_D | DEST_M, JMP_ALWAYS));
      // bits 13 and 14 are don't-care
      send_word(c_inst(FILL_CLEAR, COMP_ONE, DEST_D, JMP_NONE));
   endtask

   task automatic test_jump_wrap();
      send_word(a_inst(15'h7FFF));
      send_word(c_inst(FILL_SET, COMP_ZERO, DEST_NONE, JMP_ALWAYS));
      send_word(c_inst(FILL_SET, COMP_D_PLUS_1, DEST_D, JMP_NONE));
   endtask

   task automatic test_mem_alias();
      send_word(a_inst(15'd1023));
      send_word(c_inst(FILL_SET, COMP_MINUS_1, DEST_M, JMP_NONE));
      send_word(a_inst(15'd1024));
      send_word(c_inst(FILL_SET, COMP_M, DEST_D | DEST_M, JMP_NONE));
      send_word(a_inst(15'd1023));
      send_word(c_inst(FILL_SET, COMP_M, DEST_A | DEST_M, JMP_NONE));
   endtask

   task automatic test_program_length();
      write_prog_length(16'd0);
      send_word(a_inst(15'd3));
      send_word(c_inst(FILL_SET, COMP_BAD_A, DEST_D, JMP_NONE));
      send_word(c_inst(FILL_SET, COMP_D_PLUS_1, DEST_D, JMP_NONE));
      write_prog_length(hci_pkg::PLEN_RESET);
      send_word(a_inst(15'd0));
      write_prog_length(16'd1);
      send_word(c_inst(FILL_SET, COMP_ZERO, DEST_NONE, JMP_ALWAYS));
      send_word(c_inst(FILL_SET, COMP_ONE, DEST_D, JMP_NONE));
      write_prog_length(hci_pkg::PLEN_RESET);
   endtask

   task automatic test_random_phase(input int unsigned count, input logic [15:0] plen,
                                    input int unsigned a_span);
      // park pc at zero so a short program starts inside its range
      send_word(a_inst(15'd0));
      send_word(c_inst(FILL_SET, COMP_ZERO, DEST_NONE, JMP_ALWAYS));
      write_prog_length(plen);
      repeat (count) send_word(rand_instruction(a_span));
      write_prog_length(hci_pkg::PLEN_RESET);
   endtask

   task automatic test_backpressure();
      set_idle(0, 0);
      hold_token <= hold_token + 1;
      repeat (40) send_word(rand_instruction(1024));
   endtask

   initial begin
      cpu_a = '0;
      cpu_d = '0;
      cpu_pc = '0;
      prog_len = hci_pkg::PLEN_RESET;
      for (int i = 0; i < 1024; i++) data_mem[i] = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      set_idle(27, 64);
      test_a_loads();
      test_every_comp();
      test_bad_comp();
      test_jump_wrap();
      test_mem_alias();
      test_program_length();
      test_random_phase(150, hci_pkg::PLEN_RESET, 1024);
      set_idle(64, 27);
      test_random_phase(150, 16'd64, 64);
      set_idle(0, 0);
      test_random_phase(150, hci_pkg::PLEN_RESET, 1024);
      test_backpressure();

      wait_idle();
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== sim.f =====
src/hci_pkg.sv
src/hci_ram.sv
src/hci_alu.sv
src/hack_cpu_instruction_execute.sv
src/hci_checker.sv
tb/tb_hack_cpu_instruction_execute.sv
